/* hdl/a2r_pkg.sv */
// Shared constants, types and rounding helper for the atan2 rational-approximation pipeline.
// No dependencies; every other file in the block imports this package.
package a2r_pkg;

    localparam int INPUT_WIDTH     = 24;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ANGLE_WIDTH     = 16;

    // Ratio min/max in Q1.16, 17 bits so that 1.0 is representable
    localparam int R_FRAC      = 16;
    localparam int RATIO_BITS  = R_FRAC + 1;
    localparam int R_W         = RATIO_BITS;

    // Horner datapath: Q24 values, signed, with headroom
    localparam int NUM_W        = 27;
    localparam int PROD_W       = NUM_W + R_W + 1;
    localparam int HORNER_STEPS = 4;
    localparam int DEN_STEPS    = 2;

    // Final divider: quotient bits and working width
    localparam int QUO_W = ANGLE_FRAC_BITS + 3;
    localparam int DIV_W = NUM_W + ANGLE_FRAC_BITS + 1;

    // Angle arithmetic width before truncation to the port
    localparam int ANG_W = ANGLE_FRAC_BITS + 4;

    localparam logic signed [NUM_W-1:0] CF1    = NUM_W'(5);
    localparam logic signed [NUM_W-1:0] CF2    = NUM_W'(16776773);
    localparam logic signed [NUM_W-1:0] CF3    = NUM_W'(2473634);
    localparam logic signed [NUM_W-1:0] CF4    = NUM_W'(5200625);
    localparam logic signed [NUM_W-1:0] CF5    = NUM_W'(843924);
    localparam logic signed [NUM_W-1:0] CF6    = NUM_W'(2467994);
    localparam logic signed [NUM_W-1:0] CF7    = NUM_W'(10812313);
    localparam logic signed [NUM_W-1:0] CF_ONE = NUM_W'(16777216);

    localparam logic signed [NUM_W-1:0] NUM_INIT = -CF5;
    localparam logic signed [NUM_W-1:0] DEN_INIT = CF7;

    localparam logic signed [NUM_W-1:0] NUM_ADD [HORNER_STEPS] = '{CF4, CF3, CF2, CF1};
    localparam logic signed [NUM_W-1:0] DEN_ADD [DEN_STEPS]    = '{CF6, CF_ONE};

    // pi and pi/2 with 32 fraction bits, rounded to nearest at ANGLE_FRAC_BITS
    localparam logic [63:0] PI_Q32      = 64'd13493037705;
    localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;
    localparam logic [63:0] PI_FULL =
        (PI_Q32 + (64'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS);
    localparam logic [63:0] HALF_PI_FULL =
        (HALF_PI_Q32 + (64'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS);

    localparam logic signed [ANG_W-1:0]       PI_ANG      = ANG_W'(PI_FULL);
    localparam logic signed [ANG_W-1:0]       HALF_PI_ANG = ANG_W'(HALF_PI_FULL);
    localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_MAX   = ANGLE_WIDTH'(PI_FULL);

    typedef struct packed {
        logic swap;   // |y| > |x|: fold about pi/4
        logic xneg;
        logic yneg;
    } side_t;

    // Bring a Q24*Q16 product back to Q24, rounding half away from zero
    function automatic logic signed [NUM_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] q;
        mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        q   = (mag + (PROD_W'(1) << (R_FRAC - 1))) >> R_FRAC;
        return p[PROD_W-1] ? NUM_W'(-q) : NUM_W'(q);
    endfunction

endpackage

/* hdl/a2r_ratio_div.sv */
// Magnitude/octant stage followed by a one-bit-per-stage restoring divider for min/max.
// Depends on a2r_pkg.
module a2r_ratio_div import a2r_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic signed [INPUT_WIDTH-1:0] y_value,
    input  logic signed [INPUT_WIDTH-1:0] x_value,
    output logic                          out_valid,
    output logic [R_W-1:0]                ratio,
    output side_t                         side
);

    logic [INPUT_WIDTH-1:0] ay;
    logic [INPUT_WIDTH-1:0] ax;
    logic                   swap;

    logic                   v_reg    [RATIO_BITS+1];
    logic [INPUT_WIDTH-1:0] rem_reg  [RATIO_BITS+1];
    logic [INPUT_WIDTH-1:0] mx_reg   [RATIO_BITS+1];
    logic [R_W-1:0]         q_reg    [RATIO_BITS+1];
    logic                   zero_reg [RATIO_BITS+1];
    side_t                  side_reg [RATIO_BITS+1];

    // Most negative input maps to 2^(INPUT_WIDTH-1), exact as unsigned
    assign ay   = y_value[INPUT_WIDTH-1] ? (~$unsigned(y_value) + 1'b1) : $unsigned(y_value);
    assign ax   = x_value[INPUT_WIDTH-1] ? (~$unsigned(x_value) + 1'b1) : $unsigned(x_value);
    assign swap = ay > ax;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]       <= swap ? ax : ay;
            mx_reg[0]        <= swap ? ay : ax;
            q_reg[0]         <= '0;
            zero_reg[0]      <= (ay == '0) && (ax == '0);
            side_reg[0].swap <= swap;
            side_reg[0].xneg <= x_value[INPUT_WIDTH-1];
            side_reg[0].yneg <= y_value[INPUT_WIDTH-1];
        end
    end

    for (genvar i = 0; i < RATIO_BITS; i++)
    begin : g_bit
        logic [INPUT_WIDTH:0]   t;
        logic [INPUT_WIDTH:0]   diff;
        logic                   ge;
        logic [INPUT_WIDTH-1:0] rem_next;
        logic [R_W-1:0]         q_next;

        // First step tests the integer bit; later steps shift the remainder
        if (i == 0)
        begin : g_first
            assign t = {1'b0, rem_reg[i]};
        end
        else
        begin : g_rest
            assign t = {rem_reg[i], 1'b0};
        end

        assign ge       = t >= {1'b0, mx_reg[i]};
        assign diff     = t - {1'b0, mx_reg[i]};
        assign rem_next = ge ? diff[INPUT_WIDTH-1:0] : t[INPUT_WIDTH-1:0];
        assign q_next   = ge ? (q_reg[i] | (R_W'(1) << (RATIO_BITS - 1 - i))) : q_reg[i];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i+1]  <= rem_next;
                mx_reg[i+1]   <= mx_reg[i];
                q_reg[i+1]    <= q_next;
                zero_reg[i+1] <= zero_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = v_reg[RATIO_BITS];
    assign ratio     = zero_reg[RATIO_BITS] ? '0 : q_reg[RATIO_BITS];
    assign side      = side_reg[RATIO_BITS];

endmodule

/* hdl/a2r_poly.sv */
// Rational polynomial on the ratio: Horner steps of multiply then round-and-add.
// Depends on a2r_pkg (coefficients, round_q16).
module a2r_poly import a2r_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic [R_W-1:0]          ratio,
    input  side_t                   in_side,
    output logic                    out_valid,
    output logic signed [NUM_W-1:0] num,
    output logic signed [NUM_W-1:0] den,
    output side_t                   out_side
);

    logic                    v_b    [HORNER_STEPS+1];
    logic signed [NUM_W-1:0] n_b    [HORNER_STEPS+1];
    logic signed [NUM_W-1:0] d_b    [HORNER_STEPS+1];
    logic [R_W-1:0]          r_b    [HORNER_STEPS+1];
    side_t                   side_b [HORNER_STEPS+1];

    assign v_b[0]    = in_valid;
    assign n_b[0]    = NUM_INIT;
    assign d_b[0]    = DEN_INIT;
    assign r_b[0]    = ratio;
    assign side_b[0] = in_side;

    for (genvar s = 0; s < HORNER_STEPS; s++)
    begin : g_step
        logic                     va_reg;
        logic signed [PROD_W-1:0] pn_reg;
        logic signed [PROD_W-1:0] pd_reg;
        logic [R_W-1:0]           ra_reg;
        side_t                    sa_reg;
        logic signed [PROD_W-1:0] pn_next;
        logic signed [PROD_W-1:0] pd_next;

        logic                     vb_reg;
        logic signed [NUM_W-1:0]  n_reg;
        logic signed [NUM_W-1:0]  d_reg;
        logic [R_W-1:0]           rb_reg;
        side_t                    sb_reg;
        logic signed [NUM_W-1:0]  d_next;

        assign pn_next = n_b[s] * $signed({1'b0, r_b[s]});

        // Denominator is quadratic: later steps only delay it
        if (s < DEN_STEPS)
        begin : g_den
            assign pd_next = d_b[s] * $signed({1'b0, r_b[s]});
            assign d_next  = round_q16(pd_reg) + DEN_ADD[s];
        end
        else
        begin : g_dly
            assign pd_next = PROD_W'(d_b[s]);
            assign d_next  = pd_reg[NUM_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg <= 1'b0;
                vb_reg <= 1'b0;
            end
            else if (adv)
            begin
                va_reg <= v_b[s];
                vb_reg <= va_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pn_reg <= pn_next;
                pd_reg <= pd_next;
                ra_reg <= r_b[s];
                sa_reg <= side_b[s];
                n_reg  <= round_q16(pn_reg) + NUM_ADD[s];
                d_reg  <= d_next;
                rb_reg <= ra_reg;
                sb_reg <= sa_reg;
            end
        end

        assign v_b[s+1]    = vb_reg;
        assign n_b[s+1]    = n_reg;
        assign d_b[s+1]    = d_reg;
        assign r_b[s+1]    = rb_reg;
        assign side_b[s+1] = sb_reg;
    end

    assign out_valid = v_b[HORNER_STEPS];
    assign num       = n_b[HORNER_STEPS];
    assign den       = d_b[HORNER_STEPS];
    assign out_side  = side_b[HORNER_STEPS];

endmodule

/* hdl/a2r_angle_div.sv */
// Rounded quotient num * 2^F / den: one prep stage, then one restoring-divider stage per bit.
// Depends on a2r_pkg.
module a2r_angle_div import a2r_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [NUM_W-1:0] den,
    input  side_t                   in_side,
    output logic                    out_valid,
    output logic [QUO_W-1:0]        quot,
    output side_t                   out_side
);

    logic [NUM_W-1:0] num_clamp;
    logic [DIV_W-1:0] dividend;

    logic             v_reg    [QUO_W+1];
    logic [DIV_W-1:0] rem_reg  [QUO_W+1];
    logic [NUM_W-2:0] dq_reg   [QUO_W+1];
    logic [QUO_W-1:0] q_reg    [QUO_W+1];
    side_t            side_reg [QUO_W+1];

    // Clamp a negative numerator to zero, then add den/2 for round to nearest
    assign num_clamp = num[NUM_W-1] ? '0 : $unsigned(num);
    assign dividend  = DIV_W'({num_clamp[NUM_W-2:0], {ANGLE_FRAC_BITS{1'b0}}})
                     + DIV_W'(den[NUM_W-2:1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= dividend;
            dq_reg[0]   <= den[NUM_W-2:0];
            q_reg[0]    <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_bit
        logic [DIV_W-1:0] dsh;
        logic             ge;
        logic [DIV_W-1:0] rem_next;
        logic [QUO_W-1:0] q_next;

        assign dsh      = DIV_W'(dq_reg[i]) << (QUO_W - 1 - i);
        assign ge       = rem_reg[i] >= dsh;
        assign rem_next = ge ? (rem_reg[i] - dsh) : rem_reg[i];
        assign q_next   = ge ? (q_reg[i] | (QUO_W'(1) << (QUO_W - 1 - i))) : q_reg[i];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i+1]  <= rem_next;
                dq_reg[i+1]   <= dq_reg[i];
                q_reg[i+1]    <= q_next;
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = v_reg[QUO_W];
    assign quot      = q_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];

endmodule

/* hdl/atan2_rational_approx.sv */
// Top level of the four-quadrant arctangent pipeline; holds the fold and output register.
// Depends on a2r_pkg, a2r_ratio_div, a2r_poly and a2r_angle_div.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   input   | in_valid, in_ready, y_value[23:0], x_value | in
//   output  | out_valid, out_ready, angle[15:0]          | out
//
// One transaction enters per cycle while the output is not stalled; the stages are the magnitude
// register, the ratio divider, the polynomial, the angle divider and the fold and output register.
// The divider bit stages and the Horner multiply/round stages set the pipeline depth.
// Reset clears only the valid bits; the data registers are not reset.
// A stalled output freezes every stage together; in_ready is low only while a result waits.
module atan2_rational_approx import a2r_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [INPUT_WIDTH-1:0] y_value,
    input  logic signed [INPUT_WIDTH-1:0] x_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [ANGLE_WIDTH-1:0] angle
);

    logic                          adv;

    logic                          rat_valid;
    logic [R_W-1:0]                rat_ratio;
    side_t                         rat_side;

    logic                          poly_valid;
    logic signed [NUM_W-1:0]       poly_num;
    logic signed [NUM_W-1:0]       poly_den;
    side_t                         poly_side;

    logic                          div_valid;
    logic [QUO_W-1:0]              div_quot;
    side_t                         div_side;

    logic signed [ANG_W-1:0]       a_base;
    logic signed [ANG_W-1:0]       a_oct;
    logic signed [ANG_W-1:0]       a_quad;
    logic signed [ANG_W-1:0]       a_sign;
    logic [ANG_W+ANGLE_WIDTH-1:0]  a_ext;

    logic                          out_valid_reg;
    logic signed [ANGLE_WIDTH-1:0] angle_reg;
    logic signed [ANGLE_WIDTH-1:0] angle_next;

    // Advance the whole pipeline unless a finished result is waiting
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    a2r_ratio_div u_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .y_value   (y_value),
        .x_value   (x_value),
        .out_valid (rat_valid),
        .ratio     (rat_ratio),
        .side      (rat_side)
    );

    a2r_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (rat_valid),
        .ratio     (rat_ratio),
        .in_side   (rat_side),
        .out_valid (poly_valid),
        .num       (poly_num),
        .den       (poly_den),
        .out_side  (poly_side)
    );

    a2r_angle_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (poly_valid),
        .num       (poly_num),
        .den       (poly_den),
        .in_side   (poly_side),
        .out_valid (div_valid),
        .quot      (div_quot),
        .out_side  (div_side)
    );

    // Fold by octant, then half plane, then sign of y
    assign a_base     = $signed({1'b0, div_quot});
    assign a_oct      = div_side.swap ? (HALF_PI_ANG - a_base) : a_base;
    assign a_quad     = div_side.xneg ? (PI_ANG - a_oct) : a_oct;
    assign a_sign     = div_side.yneg ? -a_quad : a_quad;
    assign a_ext      = {{ANGLE_WIDTH{a_sign[ANG_W-1]}}, a_sign};
    assign angle_next = $signed(a_ext[ANGLE_WIDTH-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            angle_reg <= angle_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign angle     = angle_reg;

endmodule

/* hdl/a2r_checker.sv */
// Port-level checks for atan2_rational_approx, attached by the bind at the end of this file.
// Depends on a2r_pkg for widths and the pi limit.
module a2r_checker import a2r_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic signed [INPUT_WIDTH-1:0] y_value,
    input logic signed [INPUT_WIDTH-1:0] x_value,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [ANGLE_WIDTH-1:0] angle
);

    // Input side stalls only when a result sits unclaimed
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output stall");

    // Angle never leaves [-pi, +pi]
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (angle <= ANGLE_MAX) && (angle >= -ANGLE_MAX))
    else $error("angle out of range");

    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(angle))
    else $error("stalled output transaction changed");

    // A waiting input transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(y_value) && $stable(x_value))
    else $error("waiting input transaction changed");

endmodule

bind atan2_rational_approx a2r_checker u_a2r_checker (.*);

/* test/tb_atan2_rational_approx.sv */
// Self-checking testbench for atan2_rational_approx: directed table, then random vector pairs.
// Depends on a2r_pkg and the atan2_rational_approx RTL; predicts each untyped angle with its own model.
module tb_atan2_rational_approx import a2r_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY = 44;
    localparam int RANDOM_ITEMS = 1930;
    localparam int CHOKE_AT     = 400;
    localparam int CHOKE_CYCLES = 200;
    localparam int PAUSE_AT     = 1200;
    localparam int CYCLE_LIMIT  = 200000;

    // Rational approximation coefficients, Q24
    localparam longint NUM_LEAD  = -843924;
    localparam longint NUM_TAP3  = 5200625;
    localparam longint NUM_TAP2  = 2473634;
    localparam longint NUM_TAP1  = 16776773;
    localparam longint NUM_TAP0  = 5;
    localparam longint DEN_LEAD  = 10812313;
    localparam longint DEN_TAP1  = 2467994;
    localparam longint DEN_TAP0  = 16777216;
    localparam longint Q_PI      = 25736;
    localparam longint Q_HALF_PI = 12868;

    localparam int MOST_NEG = -8388608;
    localparam int MOST_POS = 8388607;

    typedef struct packed {
        int  y;
        int  x;
        bit  typed;
        int  ang;
    } dir_row_t;

    typedef struct {
        logic signed [INPUT_WIDTH-1:0] y;
        logic signed [INPUT_WIDTH-1:0] x;
        logic signed [ANGLE_WIDTH-1:0] ang;
    } angle_exp_t;

    // Axis and sign cases carry their angle; the rest go through the predictor
    dir_row_t dir_rows [24] = '{
        '{0,        0,        1'b1, 0},
        '{0,        MOST_POS, 1'b1, 0},
        '{0,        1,        1'b1, 0},
        '{0,        -1,       1'b1, 25736},
        '{0,        MOST_NEG, 1'b1, 25736},
        '{MOST_POS, 0,        1'b1, 12868},
        '{MOST_NEG, 0,        1'b1, -12868},
        '{1,        0,        1'b1, 12868},
        '{-1,       0,        1'b1, -12868},
        '{MOST_POS, MOST_POS, 1'b0, 0},
        '{MOST_NEG, MOST_NEG, 1'b0, 0},
        '{MOST_POS, MOST_NEG, 1'b0, 0},
        '{MOST_NEG, MOST_POS, 1'b0, 0},
        '{1,        1,        1'b0, 0},
        '{-1,       1,        1'b0, 0},
        '{1,        -1,       1'b0, 0},
        '{-1,       -1,       1'b0, 0},
        '{3,        4,        1'b0, 0},
        '{-4,       -3,       1'b0, 0},
        '{1,        MOST_POS, 1'b0, 0},
        '{MOST_POS, -1,       1'b0, 0},
        '{MOST_NEG, 1,        1'b0, 0},
        '{-5,       MOST_NEG, 1'b0, 0},
        '{1234567,  -7654321, 1'b0, 0}
    };

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [INPUT_WIDTH-1:0] y_value;
    logic signed [INPUT_WIDTH-1:0] x_value;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [ANGLE_WIDTH-1:0] angle;

    logic                          row_typed;
    logic signed [ANGLE_WIDTH-1:0] row_angle;
    logic                          choke_req;
    bit                            choke_done;

    angle_exp_t pending_angles[$];
    int         err_count        = 0;
    int         accepted_count   = 0;
    int         checked_count    = 0;
    int         typed_count      = 0;
    int         backed_up_cycles = 0;
    int         cycle_count      = 0;

    atan2_rational_approx i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .y_value   (y_value),
        .x_value   (x_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .angle     (angle)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // (acc * r) / 2^16, rounded half away from zero
    function automatic longint scale_q16(longint acc, longint r);
        longint mag;
        mag = (acc < 0) ? -acc : acc;
        mag = (mag * r + 32768) >>> 16;
        return (acc < 0) ? -mag : mag;
    endfunction

    function automatic logic signed [ANGLE_WIDTH-1:0] predict_angle(
        logic signed [INPUT_WIDTH-1:0] yv,
        logic signed [INPUT_WIDTH-1:0] xv
    );
        longint ay, ax, hi, lo, r, num, den, ang;
        ay = longint'(yv);
        ax = longint'(xv);
        if (ay < 0)
            ay = -ay;
        if (ax < 0)
            ax = -ax;
        hi = (ay > ax) ? ay : ax;
        lo = (ay > ax) ? ax : ay;
        r  = (hi == 0) ? 0 : (lo << 16) / hi;

        num = NUM_LEAD;
        num = scale_q16(num, r) + NUM_TAP3;
        num = scale_q16(num, r) + NUM_TAP2;
        num = scale_q16(num, r) + NUM_TAP1;
        num = scale_q16(num, r) + NUM_TAP0;
        if (num < 0)
            num = 0;
        den = DEN_LEAD;
        den = scale_q16(den, r) + DEN_TAP1;
        den = scale_q16(den, r) + DEN_TAP0;
        ang = ((num << ANGLE_FRAC_BITS) + den / 2) / den;

        // fold octant, then quadrant, then sign
        if (ay > ax)
            ang = Q_HALF_PI - ang;
        if (xv < 0)
            ang = Q_PI - ang;
        if (yv < 0)
            ang = -ang;
        return ANGLE_WIDTH'(ang);
    endfunction

    function automatic int pick_edge();
        case ($urandom_range(0, 5))
            0:       return MOST_NEG;
            1:       return MOST_NEG + 1;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            default: return MOST_POS;
        endcase
    endfunction

    // Entered and left at a falling edge; hold the payload until the transaction is taken
    task automatic send_pair(int yv, int xv, bit typed, int ang);
        in_valid  <= 1'b1;
        y_value   <= INPUT_WIDTH'(yv);
        x_value   <= INPUT_WIDTH'(xv);
        row_typed <= typed;
        row_angle <= ANGLE_WIDTH'(ang);
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic idle_for(int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain_angles();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_angles.size() != 0)
            @(negedge clk);
    endtask

    // Record accepted pairs and compare each result with the oldest expectation
    always @(posedge clk)
    begin
        angle_exp_t e;
        if (rst_n)
        begin
            if (in_valid && !in_ready)
                backed_up_cycles++;
            if (in_valid && in_ready)
            begin
                e.y   = y_value;
                e.x   = x_value;
                e.ang = row_typed ? row_angle : predict_angle(y_value, x_value);
                pending_angles.push_back(e);
                accepted_count++;
                if (row_typed)
                    typed_count++;
            end
            if (out_valid && out_ready)
            begin
                if (pending_angles.size() == 0)
                begin
                    $display("%0t: unexpected angle %0d with nothing pending", $time, angle);
                    err_count++;
                end
                else
                begin
                    e = pending_angles.pop_front();
                    checked_count++;
                    if (angle !== e.ang)
                    begin
                        $display("%0t: angle mismatch for y=%0d x=%0d: expected %0d, got %0d",
                                 $time, e.y, e.x, e.ang, angle);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles, %0d angles still pending",
                     $time, CYCLE_LIMIT, pending_angles.size());
            $display("tb_atan2_rational_approx: errors");
            $finish;
        end
    end

    // Receiver: segments of random stall patterns, plus one long hold-off on request
    initial
    begin
        int seg_left;
        int mode;
        int phase;
        int hold_left;
        out_ready  = 1'b0;
        choke_done = 1'b0;
        seg_left   = 0;
        mode       = 0;
        phase      = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (choke_req && !choke_done && hold_left == 0)
                hold_left = CHOKE_CYCLES;
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
                if (hold_left == 0)
                    choke_done = 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(20, 200);
                end
                seg_left--;
                phase++;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= (phase % 4) != 3;
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Sender: reset, directed table, random bursts
    initial
    begin
        int i;
        int mode;
        int mag;
        int delta;
        int burst_left;
        int nogap_left;
        int yv;
        int xv;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        y_value          = '0;
        x_value          = '0;
        row_typed        = 1'b0;
        row_angle        = '0;
        choke_req        = 1'b0;
        burst_left       = 0;
        nogap_left       = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[k])
            send_pair(dir_rows[k].y, dir_rows[k].x, dir_rows[k].typed, dir_rows[k].ang);
        drain_angles();

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == CHOKE_AT)
            begin
                choke_req  <= 1'b1;
                nogap_left = 3 * CHOKE_CYCLES;
            end
            if (i == PAUSE_AT)
                drain_angles();
            if (burst_left == 0)
            begin
                if (nogap_left == 0)
                    idle_for(($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 6));
                burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
            end
            burst_left--;
            if (nogap_left > 0)
                nogap_left--;

            mode = $urandom_range(0, 9);
            case (mode)
                0, 1, 2, 3:
                begin
                    yv = int'($urandom);
                    xv = int'($urandom);
                end
                4:
                begin
                    yv = int'($urandom_range(0, 32)) - 16;
                    xv = int'($urandom_range(0, 32)) - 16;
                end
                5:
                begin
                    // on an axis
                    yv = int'($urandom);
                    xv = 0;
                    if ($urandom_range(0, 1))
                    begin
                        xv = yv;
                        yv = 0;
                    end
                end
                6:
                begin
                    // magnitudes equal or nearly so, around the octant fold
                    mag   = $urandom_range(2, MOST_POS - 2);
                    delta = ($urandom_range(0, 1)) ? 0 : int'($urandom_range(0, 4)) - 2;
                    yv    = $urandom_range(0, 1) ? mag : -mag;
                    xv    = $urandom_range(0, 1) ? mag + delta : -(mag + delta);
                end
                7:
                begin
                    yv = pick_edge();
                    xv = pick_edge();
                end
                8:
                begin
                    // very small ratio
                    yv = int'($urandom);
                    xv = int'($urandom_range(0, 255)) - 128;
                    if ($urandom_range(0, 1))
                    begin
                        mag = yv;
                        yv  = xv;
                        xv  = mag;
                    end
                end
                default:
                begin
                    yv = int'($signed(INPUT_WIDTH'($urandom))) >>> $urandom_range(0, 22);
                    xv = int'($signed(INPUT_WIDTH'($urandom))) >>> $urandom_range(0, 22);
                end
            endcase
            send_pair(yv, xv, 1'b0, 0);
        end

        drain_angles();
        repeat (PIPE_LATENCY + 20) @(negedge clk);

        $display("covered %0d transactions (%0d with typed angles), %0d angles checked",
                 accepted_count, typed_count, checked_count);
        $display("input held off %0d cycles while results backed up", backed_up_cycles);
        if (err_count == 0 && pending_angles.size() == 0)
            $display("tb_atan2_rational_approx: clean");
        else
            $display("tb_atan2_rational_approx: errors");
        $finish;
    end

endmodule
